>>> rtl/indexed_max_heap_queue_core_assert.svh
// Assertion macros used by the checker file.
`ifndef INDEXED_MAX_HEAP_QUEUE_CORE_ASSERT_SVH
`define INDEXED_MAX_HEAP_QUEUE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define IMHQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that also runs while reset is asserted.
`define IMHQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> rtl/imhq_pkg.sv
package imhq_pkg;
  localparam int unsigned HeapDepthDefault = 1024;
  localparam int unsigned PrioBitsDefault  = 32;
  localparam int unsigned JobW   = 10;
  localparam int unsigned JobCnt = 1024;
  localparam int unsigned StatW  = 3;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdRemove = 2'd1;
  localparam logic [1:0] CmdChange = 2'd2;
  // Unused command code; it leaves the heap untouched and reports ok.
  localparam logic [1:0] CmdSpare  = 2'd3;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StFull   = 3'd1;
  localparam logic [2:0] StEmpty  = 3'd2;
  localparam logic [2:0] StDup    = 3'd3;
  localparam logic [2:0] StAbsent = 3'd4;
endpackage

>>> rtl/indexed_max_heap_queue_core.sv
// Channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | command, priority_req, job_id
// out     | output    | out_valid/out_stall | top_priority, top_job_id, heap_empty, status
// One request walks the heap level by level, reading and writing through the
// single-port slot memory one access at a time.
// After reset a clearing pass writes every entry of the presence table; in_stall
// is high during it and while a request is in progress or its result is not taken.
module indexed_max_heap_queue_core #(
  parameter int unsigned HEAP_DEPTH    = imhq_pkg::HeapDepthDefault,
  parameter int unsigned PRIORITY_BITS = imhq_pkg::PrioBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 command_i,
  input  logic signed [31:0]         priority_req_i,
  input  logic [imhq_pkg::JobW-1:0]  job_id_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         top_priority_o,
  output logic [imhq_pkg::JobW-1:0]  top_job_id_o,
  output logic                       heap_empty_o,
  output logic [imhq_pkg::StatW-1:0] status_o
);
  localparam int unsigned PW  = (PRIORITY_BITS < 32) ? PRIORITY_BITS : 32;
  localparam int unsigned SW  = $clog2(HEAP_DEPTH);
  localparam int unsigned CW  = SW + 1;
  localparam int unsigned JW  = imhq_pkg::JobW;
  localparam int unsigned EW  = PW + JW;

  typedef enum logic [13:0] {
    S_CLR    = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_CHK    = 14'b00000000000100,
    S_UPRD   = 14'b00000000001000,
    S_UPCMP  = 14'b00000000010000,
    S_SWAPA  = 14'b00000000100000,
    S_SWAPB  = 14'b00000001000000,
    S_DNRDL  = 14'b00000010000000,
    S_DNRDR  = 14'b00000100000000,
    S_DNCMP  = 14'b00001000000000,
    S_TOPRD  = 14'b00010000000000,
    S_TOPWT  = 14'b00100000000000,
    S_OUT    = 14'b01000000000000,
    S_POSRD  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Current element being sifted, kept in registers.
  logic signed [PW-1:0] cur_p_q, cur_p_d;
  logic [JW-1:0]        cur_j_q, cur_j_d;
  logic [SW-1:0]        pos_q, pos_d;
  logic [SW-1:0]        oth_q, oth_d;
  logic signed [PW-1:0] oth_p_q, oth_p_d;
  logic [JW-1:0]        oth_j_q, oth_j_d;
  logic                 lhas_q, lhas_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [1:0]           cmd_q, cmd_d;
  logic [2:0]           st_q, st_d;
  logic [1:0]           wait_q, wait_d;
  logic                 rd_l_q, rd_l_d;
  logic [JW-1:0]        clr_q, clr_d;
  logic signed [31:0]   top_p_q, top_p_d;
  logic [JW-1:0]        top_j_q, top_j_d;

  // Slot memory and job position memory.
  logic          s_we;
  logic [SW-1:0] s_addr;
  logic [EW-1:0] s_wd, s_rd;
  logic          j_we;
  logic [JW-1:0] j_addr;
  logic [SW-1:0] j_wd, j_rd;
  logic          pr_we, pr_wd, pr_rd;
  logic [JW-1:0] pr_addr;

  imhq_ram #(.Width(EW), .Depth(HEAP_DEPTH)) u_slot (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wd), .rdata_o(s_rd));
  imhq_ram #(.Width(SW), .Depth(imhq_pkg::JobCnt)) u_pos (
    .clk_i, .we_i(j_we), .addr_i(j_addr), .wdata_i(j_wd), .rdata_o(j_rd));
  imhq_ram #(.Width(1), .Depth(imhq_pkg::JobCnt)) u_pres (
    .clk_i, .we_i(pr_we), .addr_i(pr_addr), .wdata_i(pr_wd), .rdata_o(pr_rd));

  logic signed [PW-1:0] rd_p;
  logic [JW-1:0]        rd_j;
  assign rd_p = s_rd[EW-1:JW];
  assign rd_j = s_rd[JW-1:0];

  // Shared comparator: read element against the current or held element.
  logic signed [PW-1:0] ca_p, cb_p;
  logic [JW-1:0]        ca_j, cb_j;
  logic                 above;
  imhq_cmp #(.PrioW(PW)) u_cmp (
    .a_prio_i(ca_p), .a_job_i(ca_j), .b_prio_i(cb_p), .b_job_i(cb_j), .above_o(above));

  logic          accept;
  logic [CW-1:0] lidx, ridx;
  assign accept = in_valid && !in_stall;
  assign lidx = {pos_q, 1'b1};
  assign ridx = {pos_q, 1'b0} + CW'(2);

  always_comb begin
    state_d = state_q; cur_p_d = cur_p_q; cur_j_d = cur_j_q; pos_d = pos_q;
    oth_d = oth_q; oth_p_d = oth_p_q; oth_j_d = oth_j_q; lhas_d = lhas_q;
    cnt_d = cnt_q; cmd_d = cmd_q; st_d = st_q; wait_d = wait_q; rd_l_d = rd_l_q;
    clr_d = clr_q; top_p_d = top_p_q; top_j_d = top_j_q;
    s_we = 1'b0; s_addr = pos_q; s_wd = {cur_p_q, cur_j_q};
    j_we = 1'b0; j_addr = cur_j_q; j_wd = pos_q;
    pr_we = 1'b0; pr_addr = cur_j_q; pr_wd = 1'b0;
    ca_p = rd_p; ca_j = rd_j; cb_p = cur_p_q; cb_j = cur_j_q;
    unique case (state_q)
      // Clear the presence table after reset.
      S_CLR: begin
        pr_we = 1'b1; pr_addr = clr_q;
        clr_d = clr_q + JW'(1);
        if (clr_q == JW'(imhq_pkg::JobCnt - 1)) state_d = S_IDLE;
      end
      // Take a request and start the lookups; no upward move has been made yet.
      S_IDLE: begin
        if (accept) begin
          cmd_d = command_i; cur_p_d = priority_req_i[PW-1:0]; cur_j_d = job_id_i;
          st_d = imhq_pkg::StOk; wait_d = 2'd0; rd_l_d = 1'b0;
          pr_addr = job_id_i; j_addr = job_id_i; s_addr = '0;
          state_d = S_CHK;
        end
      end
      // Presence and position read data valid; decide the command.
      S_CHK: begin
        unique case (cmd_q)
          imhq_pkg::CmdInsert: begin
            if (cnt_q >= CW'(HEAP_DEPTH)) begin
              st_d = imhq_pkg::StFull; state_d = S_TOPRD;
            end else if (pr_rd) begin
              st_d = imhq_pkg::StDup; state_d = S_TOPRD;
            end else begin
              pr_we = 1'b1; pr_wd = 1'b1;
              pos_d = cnt_q[SW-1:0]; cnt_d = cnt_q + CW'(1);
              state_d = S_UPRD;
            end
          end
          imhq_pkg::CmdRemove: begin
            if (cnt_q == '0) begin
              st_d = imhq_pkg::StEmpty; state_d = S_TOPRD;
            end else begin
              // s_rd holds slot 0; clear its presence, then fetch the last.
              pr_we = 1'b1; pr_addr = rd_j;
              cnt_d = cnt_q - CW'(1);
              s_addr = SW'(cnt_q - CW'(1));
              pos_d = '0;
              state_d = S_POSRD;
            end
          end
          imhq_pkg::CmdChange: begin
            if (!pr_rd || CW'(j_rd) >= cnt_q) begin
              st_d = imhq_pkg::StAbsent; state_d = S_TOPRD;
            end else begin
              pos_d = j_rd; state_d = S_UPRD;
            end
          end
          default: state_d = S_TOPRD;
        endcase
      end
      // Removal: last element read; unless the heap is now empty, it becomes the sinking element.
      S_POSRD: begin
        if (cnt_q == '0) begin
          state_d = S_TOPRD;
        end else begin
          cur_p_d = rd_p; cur_j_d = rd_j; pos_d = '0; state_d = S_DNRDL;
        end
      end
      // Read the parent of the current slot; at the root, stop rising.
      S_UPRD: begin
        if (pos_q == '0) begin
          state_d = (cmd_q == imhq_pkg::CmdInsert) ? S_SWAPB : S_DNRDL;
          oth_d = pos_q;
        end else begin
          oth_d = SW'((pos_q - SW'(1)) >> 1);
          s_addr = SW'((pos_q - SW'(1)) >> 1);
          state_d = S_UPCMP;
        end
      end
      // Compare current with parent: move parent down when current ranks above.
      S_UPCMP: begin
        ca_p = cur_p_q; ca_j = cur_j_q; cb_p = rd_p; cb_j = rd_j;
        if (above) begin
          s_we = 1'b1; s_addr = pos_q; s_wd = s_rd;
          j_we = 1'b1; j_addr = rd_j; j_wd = pos_q;
          pos_d = oth_q; rd_l_d = 1'b1; state_d = S_UPRD;
        end else if (cmd_q == imhq_pkg::CmdInsert || rd_l_q) begin
          state_d = S_SWAPB;
        end else begin
          state_d = S_DNRDL;
        end
      end
      // Read the left child, or finish when there is none.
      S_DNRDL: begin
        rd_l_d = 1'b0;
        if (lidx >= cnt_q) begin
          state_d = S_SWAPB;
        end else begin
          s_addr = lidx[SW-1:0]; state_d = S_DNRDR;
        end
      end
      // Latch the better of current and left child, then read the right child.
      S_DNRDR: begin
        lhas_d = above;
        oth_d = lidx[SW-1:0]; oth_p_d = rd_p; oth_j_d = rd_j;
        if (ridx >= cnt_q) begin
          state_d = S_SWAPA;
        end else begin
          s_addr = ridx[SW-1:0]; state_d = S_DNCMP;
        end
      end
      // Compare right child with the best so far.
      S_DNCMP: begin
        if (lhas_q) begin
          cb_p = oth_p_q; cb_j = oth_j_q;
        end
        if (above) begin
          oth_d = ridx[SW-1:0]; oth_p_d = rd_p; oth_j_d = rd_j; lhas_d = 1'b1;
        end
        state_d = S_SWAPA;
      end
      // Move the winning child up or finish.
      S_SWAPA: begin
        if (lhas_q) begin
          s_we = 1'b1; s_addr = pos_q; s_wd = {oth_p_q, oth_j_q};
          j_we = 1'b1; j_addr = oth_j_q; j_wd = pos_q;
          pos_d = oth_q; state_d = S_DNRDL;
        end else begin
          state_d = S_SWAPB;
        end
      end
      // Place the current element at its final slot.
      S_SWAPB: begin
        s_we = 1'b1; j_we = 1'b1; state_d = S_TOPRD;
      end
      // Read slot 0 for the report.
      S_TOPRD: begin
        s_addr = '0; state_d = S_TOPWT;
      end
      S_TOPWT: begin
        if (cnt_q == '0) begin
          top_p_d = -32'sd1; top_j_d = '0;
        end else begin
          top_p_d = 32'(rd_p); top_j_d = rd_j;
        end
        state_d = S_OUT;
      end
      // Hold the result until taken.
      S_OUT: begin
        if (!out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; cnt_q <= '0; clr_q <= '0; rd_l_q <= 1'b0; wait_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; clr_q <= clr_d; rd_l_q <= rd_l_d;
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_p_q <= cur_p_d; cur_j_q <= cur_j_d; pos_q <= pos_d; oth_q <= oth_d;
    oth_p_q <= oth_p_d; oth_j_q <= oth_j_d; lhas_q <= lhas_d; cmd_q <= cmd_d;
    st_q <= st_d; top_p_q <= top_p_d; top_j_q <= top_j_d;
  end

  assign in_stall       = (state_q != S_IDLE);
  assign out_valid      = (state_q == S_OUT) && (wait_q == 2'd0);
  assign top_priority_o = top_p_q;
  assign top_job_id_o   = top_j_q;
  assign heap_empty_o   = (cnt_q == '0);
  assign status_o       = st_q;
endmodule

>>> rtl/imhq_ram.sv
// Single-port RAM with registered read.
module imhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Read data registered; a read of the address being written returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/imhq_cmp.sv
// Shared rank comparator: a ranks strictly above b.
module imhq_cmp #(
  parameter int unsigned PrioW = 32
) (
  input  logic signed [PrioW-1:0]        a_prio_i,
  input  logic [imhq_pkg::JobW-1:0]      a_job_i,
  input  logic signed [PrioW-1:0]        b_prio_i,
  input  logic [imhq_pkg::JobW-1:0]      b_job_i,
  output logic                           above_o
);
  always_comb begin
    if (a_prio_i != b_prio_i) begin
      above_o = a_prio_i > b_prio_i;
    end else begin
      above_o = a_job_i > b_job_i;
    end
  end
endmodule

>>> rtl/imhq_checker.sv
`include "indexed_max_heap_queue_core_assert.svh"
// Port-level checks on the queue core.
module imhq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        heap_empty_o,
  input logic [2:0]  status_o,
  input logic [31:0] top_priority_o,
  input logic [9:0]  top_job_id_o
);
  `IMHQ_ASSERT(a_busy, clk_i, rst_ni, out_valid |-> in_stall, "request taken while result pending")
  `IMHQ_ASSERT(a_hold, clk_i, rst_ni, (out_valid && out_stall) |=> (out_valid && $stable(status_o)), "stalled result changed")
  `IMHQ_ASSERT(a_emp, clk_i, rst_ni, (out_valid && heap_empty_o) |-> (top_job_id_o == 10'd0 && top_priority_o == 32'hFFFFFFFF), "empty top not fixed")
  `IMHQ_ASSERT(a_st, clk_i, rst_ni, out_valid |-> (status_o <= 3'd4), "status code out of range")
endmodule

bind indexed_max_heap_queue_core imhq_checker u_imhq_checker (.*);

>>> tb/tb_indexed_max_heap_queue_core.sv
`default_nettype none

module tb_indexed_max_heap_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 1024;

  // One reported top-of-heap view.
  typedef struct packed {
    logic signed [31:0]         prio;
    logic [imhq_pkg::JobW-1:0]  id;
    logic                       empty;
    logic [imhq_pkg::StatW-1:0] status;
  } top_view_t;

  // Scoreboard holding a shadow heap with its position map.
  class heap_scoreboard;
    logic signed [31:0]        slot_prio [Depth];
    logic [imhq_pkg::JobW-1:0] slot_job [Depth];
    int                        slot_of_job [imhq_pkg::JobCnt];
    bit                        present [imhq_pkg::JobCnt];
    int                        entries;
    top_view_t                 expected_q [$];
    int                        mismatches;

    function new();
      foreach (present[i]) present[i] = 1'b0;
      entries = 0;
      mismatches = 0;
    endfunction

    // True when slot a orders strictly above slot b; larger id breaks a tie.
    function bit outranks(int a, int b);
      if (slot_prio[a] != slot_prio[b]) return slot_prio[a] > slot_prio[b];
      return slot_job[a] > slot_job[b];
    endfunction

    function void swap_slots(int a, int b);
      logic signed [31:0]        p;
      logic [imhq_pkg::JobW-1:0] j;
      p = slot_prio[a];
      j = slot_job[a];
      slot_prio[a] = slot_prio[b];
      slot_job[a] = slot_job[b];
      slot_prio[b] = p;
      slot_job[b] = j;
      slot_of_job[slot_job[a]] = a;
      slot_of_job[slot_job[b]] = b;
    endfunction

    function void sift_up(int pos);
      while (pos > 0 && outranks(pos, (pos - 1) / 2)) begin
        swap_slots(pos, (pos - 1) / 2);
        pos = (pos - 1) / 2;
      end
    endfunction

    function void sift_down(int pos);
      int l;
      int best;
      forever begin
        l = 2 * pos + 1;
        best = pos;
        if (l < entries && outranks(l, best)) best = l;
        if (l + 1 < entries && outranks(l + 1, best)) best = l + 1;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    endfunction

    // Applies an accepted request to the shadow heap and queues its result.
    function void note(logic [1:0] cmd, logic signed [31:0] prio,
                       logic [imhq_pkg::JobW-1:0] id);
      top_view_t v;
      int pos;
      v.status = imhq_pkg::StOk;
      case (cmd)
        imhq_pkg::CmdInsert: begin
          if (entries >= Depth) v.status = imhq_pkg::StFull;
          else if (present[id]) v.status = imhq_pkg::StDup;
          else begin
            slot_prio[entries] = prio;
            slot_job[entries] = id;
            slot_of_job[id] = entries;
            present[id] = 1'b1;
            entries++;
            sift_up(entries - 1);
          end
        end
        imhq_pkg::CmdRemove: begin
          if (entries == 0) v.status = imhq_pkg::StEmpty;
          else begin
            present[slot_job[0]] = 1'b0;
            if (entries > 1) swap_slots(0, entries - 1);
            entries--;
            sift_down(0);
          end
        end
        imhq_pkg::CmdChange: begin
          if (!present[id]) v.status = imhq_pkg::StAbsent;
          else begin
            pos = slot_of_job[id];
            slot_prio[pos] = prio;
            if (pos > 0 && outranks(pos, (pos - 1) / 2)) sift_up(pos);
            else sift_down(pos);
          end
        end
        default: ;
      endcase
      if (entries == 0) begin
        v.prio = -32'sd1;
        v.id = '0;
        v.empty = 1'b1;
      end else begin
        v.prio = slot_prio[0];
        v.id = slot_job[0];
        v.empty = 1'b0;
      end
      expected_q.push_back(v);
    endfunction

    // Compares one result against the oldest expectation.
    function void check(top_view_t got);
      top_view_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected prio %0d id %0d empty %0b status %0d, got prio %0d id %0d empty %0b status %0d",
                   want.prio, want.id, want.empty, want.status,
                   got.prio, got.id, got.empty, got.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command_i = imhq_pkg::CmdInsert;
  logic signed [31:0] priority_req_i = '0;
  logic [imhq_pkg::JobW-1:0] job_id_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] top_priority_o;
  logic [imhq_pkg::JobW-1:0] top_job_id_o;
  logic heap_empty_o;
  logic [imhq_pkg::StatW-1:0] status_o;

  heap_scoreboard sb = new();
  bit hold_req = 1'b0;
  bit send_quiet = 1'b0;

  indexed_max_heap_queue_core dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .command_i, .priority_req_i, .job_id_i,
    .out_valid, .out_stall, .top_priority_o, .top_job_id_o, .heap_empty_o, .status_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(logic [1:0] cmd, logic signed [31:0] prio,
                              logic [imhq_pkg::JobW-1:0] id);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command_i <= cmd;
    priority_req_i <= prio;
    job_id_i <= id;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    sb.note(cmd, prio, id);
  endtask

  function automatic logic signed [31:0] pick_prio();
    if ($urandom_range(0, 1)) return $signed($urandom_range(0, 7)) - 3;
    return $signed($urandom);
  endfunction

  function automatic logic [imhq_pkg::JobW-1:0] pick_id();
    if ($urandom_range(0, 7) == 0)
      return imhq_pkg::JobW'($urandom_range(0, imhq_pkg::JobCnt - 1));
    return imhq_pkg::JobW'($urandom_range(0, 15));
  endfunction

  // Random mix of commands over a small id pool (unless wide_ids) so that duplicates, absent ids and ties occur.
  task automatic random_mix(int n, bit wide_ids);
    int r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) == 0) send_quiet = !send_quiet;
      r = $urandom_range(0, 99);
      if (r < 45)
        send_request(imhq_pkg::CmdInsert, pick_prio(),
                     wide_ids ? imhq_pkg::JobW'($urandom) : pick_id());
      else if (r < 75)
        send_request(imhq_pkg::CmdRemove, pick_prio(), imhq_pkg::JobW'($urandom));
      else if (r < 97)
        send_request(imhq_pkg::CmdChange, pick_prio(),
                     wide_ids ? imhq_pkg::JobW'($urandom) : pick_id());
      else
        send_request(imhq_pkg::CmdSpare, pick_prio(), imhq_pkg::JobW'($urandom));
    end
  endtask

  // Result side: random stalls per request, with quiet stretches and one long hold.
  initial begin
    int n;
    bit quiet;
    quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 99) == 0) quiet = !quiet;
      n = hold_req ? 400 : (quiet ? 0 : $urandom_range(0, 8));
      hold_req = 1'b0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check('{top_priority_o, top_job_id_o, heap_empty_o, status_o});
  end

  // Stimulus.
  initial begin
    int perm [imhq_pkg::JobCnt];
    int k;
    int t;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: empty heap errors, ties, extremes, unused code.
    send_request(imhq_pkg::CmdRemove, 0, 0);
    send_request(imhq_pkg::CmdChange, 5, 7);
    send_request(imhq_pkg::CmdSpare, 0, 0);
    send_request(imhq_pkg::CmdInsert, 32'sh7fffffff, 0);
    send_request(imhq_pkg::CmdInsert, 32'sh80000000, 1023);
    send_request(imhq_pkg::CmdInsert, 32'sh7fffffff, 5);
    send_request(imhq_pkg::CmdInsert, 3, 0);
    send_request(imhq_pkg::CmdChange, 32'sh7fffffff, 1023);
    send_request(imhq_pkg::CmdChange, 32'sh80000000, 5);
    send_request(imhq_pkg::CmdInsert, 0, 512);
    send_request(imhq_pkg::CmdInsert, -1, 682);
    send_request(imhq_pkg::CmdChange, 0, 341);
    send_request(imhq_pkg::CmdRemove, 0, 0);
    send_request(imhq_pkg::CmdChange, 7, 0);
    send_request(imhq_pkg::CmdSpare, 32'sh55555555, 1023);
    send_request(imhq_pkg::CmdRemove, 0, 0);
    send_request(imhq_pkg::CmdRemove, 0, 0);
    send_request(imhq_pkg::CmdRemove, 0, 0);
    send_request(imhq_pkg::CmdRemove, 0, 0);
    send_request(imhq_pkg::CmdRemove, 0, 0);

    // Random traffic; the result side holds off midway so the block backs up.
    random_mix(200, 1'b0);
    hold_req = 1'b1;
    random_mix(150, 1'b0);
    // Sender withdraws and pauses until the block has drained.
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    random_mix(200, 1'b0);

    // Empty the heap, then fill every id in random order and overfill it.
    while (sb.entries > 0) send_request(imhq_pkg::CmdRemove, pick_prio(), 0);
    foreach (perm[i]) perm[i] = i;
    for (int i = imhq_pkg::JobCnt - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[k];
      perm[k] = t;
    end
    foreach (perm[i])
      send_request(imhq_pkg::CmdInsert, pick_prio(), imhq_pkg::JobW'(perm[i]));
    send_request(imhq_pkg::CmdInsert, 0, imhq_pkg::JobW'(perm[0]));
    send_request(imhq_pkg::CmdInsert, 1, 77);
    random_mix(150, 1'b1);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("tb_indexed_max_heap_queue_core OK");
    else
      $display("tb_indexed_max_heap_queue_core NOT OK");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb_indexed_max_heap_queue_core NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

>>> indexed_max_heap_queue_core.f
+incdir+rtl
rtl/imhq_pkg.sv
rtl/imhq_ram.sv
rtl/imhq_cmp.sv
rtl/indexed_max_heap_queue_core.sv
rtl/imhq_checker.sv
tb/tb_indexed_max_heap_queue_core.sv
